/* hdl/pli_pkg.sv */
`default_nettype none
package pli_pkg;
  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int CNT_W         = 7;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Request passed from the front end to the back end.
  typedef struct packed {
    logic               kind;
    logic [5:0]         idx;
    logic [DATA_W-1:0]  kpos;
    logic [DATA_W-1:0]  kval;
    logic [DATA_W-1:0]  query;
  } pli_req_t;

  // Result fields, highest bit first in the output word.
  typedef struct packed {
    logic              sat;
    logic              oor;
    logic [5:0]        seg;
    logic [DATA_W-1:0] value;
  } pli_res_t;
endpackage
`default_nettype wire

/* hdl/pli_ram.sv */
`default_nettype none
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/pli_front.sv */
`default_nettype none
module pli_front #(
  parameter int MAX_KNOTS = 64,
  parameter int AW        = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  req_type,
  input  wire logic [5:0]            entry_index,
  input  wire logic [31:0]           knot_position,
  input  wire logic [31:0]           knot_value,
  input  wire logic [31:0]           query_position,
  output      logic                  tab_we,
  output      logic [AW-1:0]         tab_waddr,
  output      logic [31:0]           tab_wpos,
  output      logic [31:0]           tab_wval,
  output      logic                  q_valid,
  input  wire logic                  q_ready,
  output      pli_pkg::pli_req_t     q_data
);
  import pli_pkg::*;

  // Two-entry queue between front and back.
  pli_req_t  fifo_r [2];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push, pop;
  pli_req_t  req;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rp_r];

  assign req.kind  = req_type;
  assign req.idx   = entry_index;
  assign req.kpos  = knot_position;
  assign req.kval  = knot_value;
  assign req.query = query_position;

  // Write a load into the table as it leaves the queue, after every earlier
  // evaluate has finished reading.
  assign tab_we    = pop && (q_data.kind == REQ_LOAD) &&
                     ({26'd0, q_data.idx} < 32'(MAX_KNOTS));
  assign tab_waddr = AW'(q_data.idx);
  assign tab_wpos  = q_data.kpos;
  assign tab_wval  = q_data.kval;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wp_r] <= req;
    end
  end
endmodule
`default_nettype wire

/* hdl/pli_back.sv */
`default_nettype none
module pli_back #(
  parameter int MAX_KNOTS = 64,
  parameter int AW        = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [6:0]        knot_count,
  input  wire logic              q_valid,
  output      logic              q_ready,
  input  wire pli_pkg::pli_req_t q_data,
  output      logic [AW-1:0]     tab_raddr,
  input  wire logic [31:0]       tab_rpos,
  input  wire logic [31:0]       tab_rval,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              res_kind,
  output      pli_pkg::pli_res_t res
);
  import pli_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_WAIT  = 10'b0000000100,
    S_CHK   = 10'b0000001000,
    S_SRCH  = 10'b0000010000,
    S_LOAD  = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  localparam int CW = AW + 1;

  state_t           st_r, st_nxt;
  logic signed [31:0] x_r;
  logic [CW-1:0]    n_r, lo_r, hi_r, seg_r;
  logic [CW-1:0]    mid;
  logic [2:0]       step_r;   // counts table reads within a phase
  logic [AW-1:0]    raddr_r;
  logic signed [31:0] x0_r, x1_r, y0_r, y1_r;
  logic             oor_r, neg_r;
  logic [32:0]      mdx_r;
  logic [63:0]      prod_r;
  logic [32:0]      rem_r;    // partial remainder
  logic [64:0]      quo_r;
  logic [6:0]       dcnt_r;
  logic [CW-1:0]    kc;
  logic signed [32:0] dx, dy, ex;
  logic [32:0]      mdy, mex;
  logic [65:0]      prod_full;
  logic [33:0]      trial;
  logic signed [65:0] sum;

  always_comb begin
    kc = (knot_count < 7'd2) ? CW'(2) :
         ({25'd0, knot_count} > 32'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : CW'(knot_count);
  end

  assign mid       = (lo_r + hi_r) >> 1;
  assign tab_raddr = raddr_r;
  assign q_ready   = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);

  assign dx  = 33'(x1_r) - 33'(x0_r);
  assign dy  = 33'(y1_r) - 33'(y0_r);
  assign ex  = 33'(x_r) - 33'(x0_r);
  assign mdy = dy[32] ? 33'(-dy) : 33'(dy);
  assign mex = ex[32] ? 33'(-ex) : 33'(ex);
  assign prod_full = mdy * mex;
  // Shift the next dividend bit into the remainder and try the subtract.
  assign trial = {rem_r, quo_r[64]} - {1'b0, mdx_r};

  // Dividend is prod + mdx/2, held as 65 bits in quo_r during division.
  assign sum = 66'(signed'(y0_r)) + (neg_r ? -66'(signed'({1'b0, quo_r})) :
                                              66'(signed'({1'b0, quo_r})));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) st_nxt = (q_data.kind == REQ_LOAD) ? S_OUT : S_RD;
      S_RD:   st_nxt = S_WAIT;
      S_WAIT: st_nxt = (step_r >= 3'd2) ? S_SRCH : S_CHK;
      S_CHK:  st_nxt = (step_r == 3'd1) ? S_SRCH : S_WAIT;
      S_SRCH: st_nxt = (hi_r - lo_r > CW'(1)) ? S_WAIT : S_LOAD;
      S_LOAD: st_nxt = (step_r == 3'd7) ? S_MUL : S_LOAD;
      S_MUL:  st_nxt = S_DIV;
      S_DIV:  st_nxt = (dcnt_r == 7'd0) ? S_FIN : S_DIV;
      S_FIN:  st_nxt = S_OUT;
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      S_IDLE: begin
        x_r     <= q_data.query;
        n_r     <= kc;
        raddr_r <= '0;
        step_r  <= 3'd0;
        res_kind <= q_data.kind;
        res     <= '0;
      end
      S_RD: begin
        // read first knot
      end
      S_WAIT: begin
      end
      S_CHK: begin
        // step 0: first knot data; step 1: last knot data
        if (step_r == 3'd0) begin
          if ($signed(x_r) < $signed(tab_rpos)) begin
            seg_r <= '0; oor_r <= 1'b1; lo_r <= '0; hi_r <= '0;
          end else begin
            oor_r <= 1'b0;
          end
          raddr_r <= AW'(n_r - CW'(1));
          step_r  <= 3'd1;
        end else begin
          if (!oor_r) begin
            if ($signed(x_r) >= $signed(tab_rpos)) begin
              seg_r <= n_r - CW'(2); oor_r <= 1'b1; lo_r <= '0; hi_r <= '0;
            end else begin
              lo_r <= '0; hi_r <= n_r - CW'(1);
              raddr_r <= AW'((n_r - CW'(1)) >> 1);
            end
          end
          step_r <= 3'd2;
        end
      end
      S_SRCH: begin
        // tab_rpos holds position[mid] of the previous address
        step_r <= (st_nxt == S_LOAD) ? 3'd4 : 3'd3;
        if (oor_r) begin
          hi_r <= '0;
        end else if (step_r == 3'd2) begin
          if (hi_r - lo_r > CW'(1)) raddr_r <= AW'(mid);
          else seg_r <= lo_r;
        end else begin
          if ($signed(tab_rpos) <= $signed(x_r)) begin
            lo_r <= mid;
            if (hi_r - mid > CW'(1)) raddr_r <= AW'((mid + hi_r) >> 1);
            else seg_r <= mid;
          end else begin
            hi_r <= mid;
            if (mid - lo_r > CW'(1)) raddr_r <= AW'((lo_r + mid) >> 1);
            else seg_r <= lo_r;
          end
        end
      end
      S_LOAD: begin
        // 4: issue seg, 5: issue seg+1, 6: data seg, 7: data seg+1
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) raddr_r <= AW'(seg_r);
        if (step_r == 3'd5) raddr_r <= AW'(seg_r + CW'(1));
        if (step_r == 3'd6) begin x0_r <= tab_rpos; y0_r <= tab_rval; end
        if (step_r == 3'd7) begin x1_r <= tab_rpos; y1_r <= tab_rval; end
      end
      S_MUL: begin
        prod_r <= prod_full[63:0];
        mdx_r  <= dx[32] ? 33'(-dx) : 33'(dx);
        neg_r  <= (dy[32] ^ ex[32]) ^ dx[32];
        rem_r  <= '0;
        dcnt_r <= 7'd65;
        step_r <= 3'd0;
      end
      S_DIV: begin
        if (step_r == 3'd0) begin
          quo_r  <= 65'(prod_r) + 65'(mdx_r >> 1);
          step_r <= 3'd1;
        end else if (dcnt_r != 7'd0) begin
          // restoring division, one quotient bit a cycle
          if (!trial[33]) begin
            rem_r <= trial[32:0];
            quo_r <= {quo_r[63:0], 1'b1};
          end else begin
            rem_r <= {rem_r[31:0], quo_r[64]};
            quo_r <= {quo_r[63:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 7'd1;
        end
      end
      S_FIN: begin
        res.seg <= 6'(seg_r);
        res.oor <= oor_r;
        if (mdx_r == 33'd0) begin
          res.value <= y0_r; res.sat <= 1'b0;
        end else if (quo_r > 65'h400000000) begin
          res.value <= neg_r ? 32'h80000000 : 32'h7fffffff; res.sat <= 1'b1;
        end else if (sum > 66'sh7fffffff) begin
          res.value <= 32'h7fffffff; res.sat <= 1'b1;
        end else if (sum < -66'sh80000000) begin
          res.value <= 32'h80000000; res.sat <= 1'b1;
        end else begin
          res.value <= sum[31:0]; res.sat <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

/* hdl/piecewise_linear_interpolator.sv */
`default_nettype none
// Piecewise linear interpolator. A load item (req_type 0) writes one knot
// (position, value) into the table and is acknowledged by one result with
// result_kind 0; an evaluate item (req_type 1) finds by binary search the
// segment holding query_position among the first knot_count knots, and returns
// the interpolated Q16.16 value, extrapolating along the end segments, rounded
// to nearest and saturated. An evaluate checks the query against the first
// and last knots; when it lies between them and more than two knots are in
// use, the search runs one step more than log2 of the segment count rounded
// up, reading the registered table port. The two knots of the segment are then
// read, and a 65-step restoring divider, with a setup and a closing step, forms
// the result. A two-entry queue parts the front end, which accepts items, from
// the back end that computes one item at a time; a load is written into the
// table as it leaves the queue, so earlier evaluates see the old table. With
// the back end busy, the queue takes two more items and then holds the input
// off.
module piecewise_linear_interpolator #(
  parameter int MAX_KNOTS = pli_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata,     // knot_count
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // entry_index[5:0], knot_position[37:6], knot_value[69:38],
  // query_position[101:70], zero fill to 104
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,  // req_type
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // interpolated[31:0], segment_index[37:32], out_of_range[38], saturated[39]
  output      logic [39:0]  m_axis_tdata,
  output      logic         m_axis_tuser   // result_kind
);
  import pli_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);

  logic [6:0]    knot_count_r;
  logic          tab_we;
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [31:0]   tab_wpos, tab_wval, tab_rpos, tab_rval;
  logic          q_valid, q_ready;
  pli_req_t      q_data;
  pli_res_t      res;
  logic          fb_unused;

  // Fraction width does not enter the arithmetic: the ratio is unitless.
  assign fb_unused = (FRAC_BITS < 0);

  // Hold the knot count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= 7'd2;
    end else if (cfg_we) begin
      knot_count_r <= cfg_wdata;
    end
  end

  pli_front #(.MAX_KNOTS(MAX_KNOTS), .AW(AW)) u_front (
    .clk, .rst_n,
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .req_type      (s_axis_tuser),
    .entry_index   (s_axis_tdata[5:0]),
    .knot_position (s_axis_tdata[37:6]),
    .knot_value    (s_axis_tdata[69:38]),
    .query_position(s_axis_tdata[101:70]),
    .tab_we, .tab_waddr, .tab_wpos, .tab_wval,
    .q_valid, .q_ready, .q_data
  );

  pli_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_pos (
    .clk, .we(tab_we), .waddr(tab_waddr), .wdata(tab_wpos),
    .raddr(tab_raddr), .rdata(tab_rpos)
  );

  pli_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_val (
    .clk, .we(tab_we), .waddr(tab_waddr), .wdata(tab_wval),
    .raddr(tab_raddr), .rdata(tab_rval)
  );

  pli_back #(.MAX_KNOTS(MAX_KNOTS), .AW(AW)) u_back (
    .clk, .rst_n,
    .knot_count(knot_count_r | {6'd0, fb_unused}),
    .q_valid, .q_ready, .q_data,
    .tab_raddr, .tab_rpos, .tab_rval,
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .res_kind (m_axis_tuser),
    .res
  );

  assign m_axis_tdata = {res.sat, res.oor, res.seg, res.value};
endmodule
`default_nettype wire

/* tb/pli_checker.sv */
`timescale 1ns / 1ps
module pli_checker
  import pli_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [103:0] in_data,
  input  logic         in_kind,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [39:0]  out_data,
  input  logic         out_kind,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] value;
    logic [5:0]        seg;
    logic              oor;
    logic              sat;
  } answer_t;

  logic [DATA_W-1:0] knot_x [64];
  logic [DATA_W-1:0] knot_y [64];
  logic [6:0]        knots_cfg;
  answer_t           answers [$];

  assign pending = answers.size();

  function automatic answer_t interpolate(logic [DATA_W-1:0] query);
    answer_t a;
    int unsigned n, lo, hi, mid, s;
    longint x, x0, x1, y0, y1, dx, dy, ex, r;
    longint unsigned mdx, p, q;
    bit neg;
    a = '0;
    a.kind = REQ_EVAL;
    n = knots_cfg < 2 ? 2 : (knots_cfg > 64 ? 64 : knots_cfg);
    x = longint'($signed(query));
    if (x < longint'($signed(knot_x[0]))) begin
      s = 0;
      a.oor = 1'b1;
    end else if (x >= longint'($signed(knot_x[n-1]))) begin
      s = n - 2;
      a.oor = 1'b1;
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (longint'($signed(knot_x[mid])) <= x) lo = mid;
        else hi = mid;
      end
      s = lo;
    end
    x0 = longint'($signed(knot_x[s]));
    x1 = longint'($signed(knot_x[s+1]));
    y0 = longint'($signed(knot_y[s]));
    y1 = longint'($signed(knot_y[s+1]));
    dx = x1 - x0;
    dy = y1 - y0;
    ex = x - x0;
    if (dx == 0) begin
      r = y0;
    end else begin
      neg = ((dy < 0) != (ex < 0)) != (dx < 0);
      mdx = dx < 0 ? -dx : dx;
      p = (dy < 0 ? -dy : dy) * (ex < 0 ? -ex : ex);
      q = (p + (mdx >> 1)) / mdx;
      if (q > 64'h4_0000_0000) begin
        r = neg ? -64'sd2147483648 : 64'sd2147483647;
        a.sat = 1'b1;
      end else begin
        r = y0 + (neg ? -longint'(q) : longint'(q));
        if (r > 64'sd2147483647) begin
          r = 64'sd2147483647;
          a.sat = 1'b1;
        end else if (r < -64'sd2147483648) begin
          r = -64'sd2147483648;
          a.sat = 1'b1;
        end
      end
    end
    a.value = r[31:0];
    a.seg = s[5:0];
    return a;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst_n) begin
      knots_cfg <= 7'd2;
      answers.delete();
    end else begin
      if (cfg_we) knots_cfg <= cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_kind == REQ_LOAD) begin
          knot_x[in_data[5:0]] = in_data[37:6];
          knot_y[in_data[5:0]] = in_data[69:38];
          answers.push_back('0);
        end else begin
          answers.push_back(interpolate(in_data[101:70]));
        end
      end
      if (out_valid && out_ready) begin
        got = {out_kind, out_data[31:0], out_data[37:32], out_data[38], out_data[39]};
        if (answers.size() == 0) begin
          $error("result with nothing expected: %h", got);
          fail_count++;
        end else begin
          want = answers.pop_front();
          if (got.kind !== want.kind) begin
            $error("result_kind expected %0d actual %0d", want.kind, got.kind);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("interpolated expected %h actual %h", want.value, got.value);
            fail_count++;
          end
          if (got.seg !== want.seg) begin
            $error("segment_index expected %0d actual %0d", want.seg, got.seg);
            fail_count++;
          end
          if (got.oor !== want.oor) begin
            $error("out_of_range expected %0d actual %0d", want.oor, got.oor);
            fail_count++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated expected %0d actual %0d", want.sat, got.sat);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import pli_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [6:0]   cfg_wdata;
  logic         in_valid;
  logic         in_ready;
  logic [103:0] in_data;    // entry_index, knot_position, knot_value, query_position
  logic         in_kind;    // req_type
  logic         out_valid;
  logic         out_ready;
  logic [39:0]  out_data;   // interpolated, segment_index, out_of_range, saturated
  logic         out_kind;   // result_kind
  int           fail_count;
  int           pending;
  int           cycles;
  int           idle_pct;   // shared idle rate of both sides, percent
  bit           hold_off;   // receiver long stall request

  // Knot count in use for the current phase; all of 0..n-1 are always loaded.
  int           n_live;

  piecewise_linear_interpolator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
    .s_axis_tdata(in_data), .s_axis_tuser(in_kind),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
    .m_axis_tdata(out_data), .m_axis_tuser(out_kind)
  );

  pli_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data), .in_kind(in_kind),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .out_kind(out_kind), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: allow heavy stalls many times over.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1500000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Offer one item and hold it until accepted; valid stays up for the next call.
  task automatic send(logic kind, logic [5:0] idx, logic [31:0] kx, logic [31:0] ky,
                      logic [31:0] qx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= {2'b00, qx, ky, kx, idx};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic set_knots(int n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n[6:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_live = (n < 2) ? 2 : (n > 64 ? 64 : n);
  endtask

  // Load an ascending table of n knots, with random spacing and values.
  task automatic load_table(int n, bit wide);
    logic [31:0] px;
    int step;
    px = wide ? 32'h8000_0000 + $urandom_range(1000) : $urandom;
    if (!wide) px = {1'b1, px[30:0]} + 32'h1000_0000;
    for (int i = 0; i < n; i++) begin
      send(REQ_LOAD, i[5:0], px, $urandom, $urandom);
      step = wide ? 32'h7FFF_FFFF / n * 2 : $urandom_range(1 << 20);
      if ($urandom_range(9) == 0) step = 0;     // zero-width segment
      px = px + step;
    end
  endtask

  task automatic eval_random();
    logic [31:0] q;
    case ($urandom_range(3))
      0: q = $urandom;
      1: q = {$urandom_range(1) ? 1'b0 : 1'b1, 31'h0} - $urandom_range(1);
      default: q = 32'h9000_0000 + $urandom_range(32'h1000_0000);
    endcase
    send(REQ_EVAL, 6'($urandom), $urandom, $urandom, q);
  endtask

  initial begin
    int cnt_list [6];
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 7'd0;
    in_valid  = 1'b0;
    in_kind   = REQ_LOAD;
    in_data   = '0;
    idle_pct  = 24;
    hold_off  = 1'b0;
    n_live    = 2;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: two knots, extremes of position and value, equal-to-last knot.
    send(REQ_LOAD, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send(REQ_LOAD, 6'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send(REQ_EVAL, 6'h3F, '1, '1, 32'h8000_0000);
    send(REQ_EVAL, 6'h3F, '1, '1, 32'h7FFF_FFFF);
    send(REQ_EVAL, 6'h00, '0, '0, 32'h0000_0000);
    // Steep segment forces saturation on extrapolation.
    send(REQ_LOAD, 6'd0, 32'h0000_0000, 32'h0000_0000, 32'h0);
    send(REQ_LOAD, 6'd1, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0);
    send(REQ_EVAL, 6'd0, '0, '0, 32'h7FFF_FFFF);
    send(REQ_EVAL, 6'd0, '0, '0, 32'h8000_0000);
    send(REQ_EVAL, 6'd0, '0, '0, 32'hFFFF_FFFF);
    // Zero-width segment.
    send(REQ_LOAD, 6'd1, 32'h0000_0000, 32'h1234_5678, 32'h0);
    send(REQ_EVAL, 6'd0, '0, '0, 32'h0000_0000);
    send(REQ_EVAL, 6'd0, '0, '0, 32'hFFFF_0000);
    // Descending table: bisection runs unchanged.
    send(REQ_LOAD, 6'd1, 32'hFFFF_0000, 32'h0001_0000, 32'h0);
    send(REQ_EVAL, 6'd0, '0, '0, 32'hFFFF_8000);
    send(REQ_EVAL, 6'd0, '0, '0, 32'h0000_8000);
    // Top slot loaded, then knot count beyond range acts as the maximum.
    drain();
    load_table(64, 1'b1);
    drain();
    set_knots(127);
    send(REQ_EVAL, 6'd0, '0, '0, 32'h7FFF_FFFF);
    send(REQ_EVAL, 6'd0, '0, '0, 32'h0000_0000);
    drain();
    set_knots(0);
    send(REQ_EVAL, 6'd0, '0, '0, 32'h0000_0000);

    // Random phases over several knot counts; table always fully loaded first.
    cnt_list = '{2, 64, 3, 17, 1, 40};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_knots(cnt_list[ph]);
      idle_pct = (ph == 2) ? 0 : 24;
      load_table(n_live, ph == 1);
      if (ph == 3) hold_off = 1'b1;     // block fills up while items keep coming
      for (int k = 0; k < 224; k++) begin
        if ($urandom_range(15) == 0)
          send(REQ_LOAD, 6'($urandom_range(n_live - 1)), $urandom, $urandom, $urandom);
        else
          eval_random();
      end
    end
    idle_pct = 24;

    drain();
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

/* filelist.f */
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/pli_front.sv
hdl/pli_back.sv
hdl/piecewise_linear_interpolator.sv
tb/pli_checker.sv
tb/testbench.sv
